@@ rtl/stq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package stq_pkg;
  localparam int NumTimersDef = 32;
  localparam int MaxResults   = 32;
  localparam int FifoDepth    = 2;

  typedef enum logic [2:0] {
    KIND_ALLOC = 3'd0,
    KIND_FREE  = 3'd1,
    KIND_SETP  = 3'd2,
    KIND_ARM   = 3'd3,
    KIND_TICK  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RES_ALLOC  = 2'd0,
    RES_FIRED  = 2'd1,
    RES_SWITCH = 2'd2
  } res_kind_t;

  typedef enum logic [1:0] {
    ST_UNUSED = 2'd0,
    ST_ALLOC  = 2'd1,
    ST_ARMED  = 2'd2
  } slot_st_t;

  // one classified command handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot;   // already range checked: bit 5 set means ignore
    logic [31:0] delay;
    logic [31:0] payload;
    logic [3:0]  queue;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/stq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Accepts commands, range checks the slot and pushes them into a small fifo.
module stq_front #(
  parameter int NUM_TIMERS = stq_pkg::NumTimersDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_start,
  input  wire logic [2:0]    in_kind,
  input  wire logic [4:0]    in_slot,
  input  wire logic [31:0]   in_delay,
  input  wire logic [31:0]   in_payload,
  input  wire logic [3:0]    in_dest_queue,
  output logic               busy,
  output logic               q_valid,
  output stq_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  import stq_pkg::*;
  localparam int DEPTH = FifoDepth;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  cmd_t            c;
  logic            push;

  always_comb begin
    c.kind    = in_kind;
    c.slot    = ({1'b0, in_slot} < 6'(NUM_TIMERS)) ? {1'b0, in_slot} : 6'h20;
    c.delay   = in_delay;
    c.payload = in_payload;
    c.queue   = in_dest_queue;
  end

  assign busy    = (cnt_r == (AW+1)'(DEPTH));
  assign push    = in_start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= c;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue count overflow");
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (cnt_r != '0)) else $error("full queue emptied at once");
`endif
endmodule
`default_nettype wire

@@ rtl/stq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Executes commands one at a time. The armed list is kept as an order array
// walked one entry per cycle (insert, unlink, expiry).
module stq_back #(
  parameter int NUM_TIMERS = stq_pkg::NumTimersDef
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_wdata,
  input  wire logic          q_valid,
  input  stq_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_strobe,
  output logic [1:0]         out_result_kind,
  output logic               out_granted,
  output logic [4:0]         out_result_slot,
  output logic [31:0]        out_fired_payload,
  output logic [3:0]         out_fired_queue,
  output logic               out_last
);
  import stq_pkg::*;
  localparam int SW = $clog2(NUM_TIMERS);
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_INS, S_SHIFT, S_EXP, S_SW, S_TS
  } state_t;

  state_t          state_r;
  cmd_t            cmd_r;
  slot_st_t        st_r [NUM_TIMERS];
  logic [31:0]     dl_r [NUM_TIMERS];
  logic [31:0]     pl_r [NUM_TIMERS];
  logic [3:0]      qu_r [NUM_TIMERS];
  logic [SW-1:0]   ord_r [NUM_TIMERS];
  logic [CW-1:0]   cnt_r;
  logic [31:0]     tick_r;
  logic [5:0]      tts_r;
  logic [CW-1:0]   i_r, j_r;
  logic [5:0]      nres_r;
  logic            ts_r;
  logic [31:0]     dnew_r;
  logic            hv_r;
  logic [SW-1:0]   hs_r;

  logic [SW-1:0]   sidx;
  logic [SW-1:0]   head;
  logic            found;
  logic [SW-1:0]   fidx;
  logic            sw_room;

  assign sidx = cmd_r.slot[SW-1:0];
  assign head = ord_r[i_r[SW-1:0]];
  assign q_pop = (state_r == S_IDLE) && q_valid;
  assign sw_room = ts_r && (nres_r < 6'(MaxResults));

  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
      if (st_r[k] == ST_UNUSED) begin
        found = 1'b1;
        fidx  = SW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      tick_r     <= '0;
      tts_r      <= 6'd32;
      out_strobe <= 1'b0;
      hv_r       <= 1'b0;
      for (int k = 0; k < NUM_TIMERS; k++) st_r[k] <= ST_UNUSED;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_we) tts_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            i_r   <= '0;
            j_r   <= '0;
            nres_r <= '0;
            ts_r  <= 1'b0;
            dnew_r <= q_cmd.delay + tick_r;
            priority case (q_cmd.kind)
              KIND_ALLOC: state_r <= S_ALLOC;
              KIND_FREE: begin
                if (!q_cmd.slot[5]) begin
                  if (st_r[q_cmd.slot[SW-1:0]] == ST_ARMED) state_r <= S_SHIFT;
                  else st_r[q_cmd.slot[SW-1:0]] <= ST_UNUSED;
                end
              end
              KIND_SETP: begin
                if (!q_cmd.slot[5]) begin
                  pl_r[q_cmd.slot[SW-1:0]] <= q_cmd.payload;
                  qu_r[q_cmd.slot[SW-1:0]] <= q_cmd.queue;
                end
              end
              KIND_ARM: begin
                if (!q_cmd.slot[5] && st_r[q_cmd.slot[SW-1:0]] == ST_ALLOC) begin
                  state_r <= S_INS;
                end
              end
              KIND_TICK: begin
                tick_r  <= tick_r + 32'd1;
                state_r <= S_EXP;
              end
              default: ;
            endcase
          end
        end
        S_ALLOC: begin
          out_strobe        <= 1'b1;
          out_result_kind   <= RES_ALLOC;
          out_granted       <= found;
          out_result_slot   <= found ? 5'(fidx) : 5'd0;
          out_fired_payload <= '0;
          out_fired_queue   <= '0;
          out_last          <= 1'b1;
          if (found) st_r[fidx] <= ST_ALLOC;
          state_r <= S_IDLE;
        end
        S_INS: begin
          // find position: first entry whose deadline >= new one
          if (i_r < cnt_r && dnew_r > dl_r[head]) begin
            i_r <= i_r + 1'b1;
          end else begin
            j_r     <= cnt_r;
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (cmd_r.kind == KIND_ARM) begin
            // shift tail up one entry per cycle, then drop the slot in
            if (j_r > i_r) begin
              ord_r[j_r[SW-1:0]] <= ord_r[SW'(j_r - 1'b1)];
              j_r <= j_r - 1'b1;
            end else begin
              ord_r[i_r[SW-1:0]] <= sidx;
              dl_r[sidx] <= dnew_r;
              st_r[sidx] <= ST_ARMED;
              cnt_r <= cnt_r + 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            // unlink: compact entries that differ from the freed slot
            if (i_r < cnt_r) begin
              if (head != sidx) begin
                ord_r[j_r[SW-1:0]] <= head;
                j_r <= j_r + 1'b1;
              end
              i_r <= i_r + 1'b1;
            end else begin
              cnt_r <= j_r;
              st_r[sidx] <= ST_UNUSED;
              state_r <= S_IDLE;
            end
          end
        end
        S_EXP: begin
          // i_r: read index, equal to the entries fired so far while firing; j_r: compaction destination index.
          // Each fire is held back until the next one or S_SW, so the final one can carry last.
          if (j_r == '0 && i_r < cnt_r && nres_r < 6'(MaxResults)
              && dl_r[head] <= tick_r) begin
            st_r[head] <= ST_ALLOC;
            if ({1'b0, head} == 6'(tts_r) && tts_r < 6'(NUM_TIMERS)) begin
              ts_r <= 1'b1;
            end else begin
              if (hv_r) begin
                out_strobe        <= 1'b1;
                out_result_kind   <= RES_FIRED;
                out_granted       <= 1'b0;
                out_result_slot   <= 5'(hs_r);
                out_fired_payload <= pl_r[hs_r];
                out_fired_queue   <= qu_r[hs_r];
                out_last          <= 1'b0;
              end
              hv_r   <= 1'b1;
              hs_r   <= head;
              nres_r <= nres_r + 1'b1;
            end
            i_r <= i_r + 1'b1;
          end else if (i_r < cnt_r && i_r != '0) begin
            // move remaining entries down by the fired count
            ord_r[j_r[SW-1:0]] <= head;
            j_r <= j_r + 1'b1;
            i_r <= i_r + 1'b1;
          end else begin
            if (i_r != '0) cnt_r <= cnt_r - (i_r - j_r);
            state_r <= S_SW;
          end
        end
        S_SW: begin
          // held fire goes out; it is last unless a switch follows
          if (hv_r) begin
            out_strobe        <= 1'b1;
            out_result_kind   <= RES_FIRED;
            out_granted       <= 1'b0;
            out_result_slot   <= 5'(hs_r);
            out_fired_payload <= pl_r[hs_r];
            out_fired_queue   <= qu_r[hs_r];
            out_last          <= !sw_room;
            hv_r              <= 1'b0;
            state_r           <= sw_room ? S_TS : S_IDLE;
          end else begin
            if (sw_room) begin
              out_strobe        <= 1'b1;
              out_result_kind   <= RES_SWITCH;
              out_granted       <= 1'b0;
              out_result_slot   <= tts_r[4:0];
              out_fired_payload <= '0;
              out_fired_queue   <= '0;
              out_last          <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_TS: begin
          out_strobe        <= 1'b1;
          out_result_kind   <= RES_SWITCH;
          out_granted       <= 1'b0;
          out_result_slot   <= tts_r[4:0];
          out_fired_payload <= '0;
          out_fired_queue   <= '0;
          out_last          <= 1'b1;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_TIMERS)) else $error("armed list overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while working");
  a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == RES_ALLOC |-> out_last)
    else $error("allocate reply not last");
`endif
endmodule
`default_nettype wire

@@ rtl/sorted_timer_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  | ports                                   | handshake
// command  | in_kind/slot/delay/payload/dest_queue   | start && !busy
// result   | out_result_kind..out_last               | out_strobe, no stall
// config   | cfg_task_timer_slot                     | cfg_we
// Commands queue in a two-beat fifo; the back end pops one whenever it is idle
// and runs one at a time. Set payload and free of an idle slot finish in the
// pop; allocate replies from S_ALLOC; free of an armed timer walks the list in
// S_SHIFT; arm walks it in S_INS, then S_SHIFT; tick walks it in S_EXP, then
// S_SW, and S_TS when a switch follows a fire.
// A fire is held back inside the back end so the final beat carries last.
// Reset (synchronous, rst_n low) empties the list and frees every slot.
// busy rises only when the fifo is full; results cannot be held off.
module sorted_timer_queue #(
  parameter int NUM_TIMERS = stq_pkg::NumTimersDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_kind,
  input  wire logic [4:0]  in_slot,
  input  wire logic [31:0] in_delay,
  input  wire logic [31:0] in_payload,
  input  wire logic [3:0]  in_dest_queue,
  input  wire logic        cfg_we,
  input  wire logic [5:0]  cfg_task_timer_slot,
  output logic             out_strobe,
  output logic [1:0]       out_result_kind,
  output logic             out_granted,
  output logic [4:0]       out_result_slot,
  output logic [31:0]      out_fired_payload,
  output logic [3:0]       out_fired_queue,
  output logic             out_last
);
  import stq_pkg::*;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  stq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk, .rst_n, .in_start(start), .in_kind, .in_slot, .in_delay, .in_payload,
    .in_dest_queue, .busy, .q_valid, .q_cmd, .q_pop
  );

  // result beats leave straight from the back end's registers
  stq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst_n, .cfg_we, .cfg_wdata(cfg_task_timer_slot), .q_valid, .q_cmd,
    .q_pop, .out_strobe, .out_result_kind, .out_granted, .out_result_slot,
    .out_fired_payload, .out_fired_queue, .out_last
  );

`ifndef SYNTHESIS
  a_switch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result_kind == RES_SWITCH |-> out_last)
    else $error("switch request not last");
  a_busy_ok: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> q_valid) else $error("busy with empty queue");
  a_grant_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_granted |-> out_result_kind == RES_ALLOC)
    else $error("grant on non-allocate beat");
`endif
endmodule
`default_nettype wire

@@ tb/sv/tb_sorted_timer_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Checks the sorted timer queue against a behavioral copy held in this bench.
// Directed tasks walk the corner cases. Three random phases follow, each with
// its own task-timer setting and its own idle pattern on the command side.
module tb_sorted_timer_queue;
  import stq_pkg::*;

  localparam int NumSlots = 32;
  localparam logic [2:0] KindReservedLo = 3'd5;
  localparam logic [2:0] KindReservedHi = 3'd7;
  localparam int IdleGuard = 200;     // longer than the slowest list walk
  localparam int MaxReports = 10;

  typedef struct {
    res_kind_t   rkind;
    bit          granted;
    bit [4:0]    slot;
    bit [31:0]   payload;
    bit [3:0]    queue;
    bit          last;
  } timer_event_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_kind;
  logic [4:0]  in_slot;
  logic [31:0] in_delay;
  logic [31:0] in_payload;
  logic [3:0]  in_dest_queue;
  logic        cfg_we;
  logic [5:0]  cfg_task_timer_slot;
  logic        out_strobe;
  logic [1:0]  out_result_kind;
  logic        out_granted;
  logic [4:0]  out_result_slot;
  logic [31:0] out_fired_payload;
  logic [3:0]  out_fired_queue;
  logic        out_last;

  sorted_timer_queue uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_slot(in_slot), .in_delay(in_delay),
    .in_payload(in_payload), .in_dest_queue(in_dest_queue),
    .cfg_we(cfg_we), .cfg_task_timer_slot(cfg_task_timer_slot),
    .out_strobe(out_strobe), .out_result_kind(out_result_kind),
    .out_granted(out_granted), .out_result_slot(out_result_slot),
    .out_fired_payload(out_fired_payload), .out_fired_queue(out_fired_queue),
    .out_last(out_last)
  );

  // shadow of the timer pool
  bit [31:0]   now_ticks;
  slot_st_t    slot_state [NumSlots];
  bit [31:0]   slot_deadline [NumSlots];
  bit [31:0]   slot_pay [NumSlots];
  bit [3:0]    slot_dest [NumSlots];
  bit          slot_written [NumSlots];
  int          armed_list [$];       // armed slots, earliest deadline first
  bit [5:0]    task_slot;

  timer_event_t pending_events [$];

  int idle_pct;
  int beats_sent;
  int events_seen;
  int fires_seen;
  int switches_seen;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d events still outstanding", pending_events.size());
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  task automatic model_command(input logic [2:0] kind, input bit [4:0] s,
                               input bit [31:0] delay, input bit [31:0] pay,
                               input bit [3:0] dq);
    timer_event_t ev;
    int n;
    int pos;
    int head;
    bit want_switch;
    n = 0;
    ev = '{RES_ALLOC, 1'b0, 5'd0, 32'd0, 4'd0, 1'b0};
    case (kind)
      KIND_ALLOC: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (slot_state[i] == ST_UNUSED) begin
            slot_state[i] = ST_ALLOC;
            ev.granted = 1'b1;
            ev.slot = 5'(i);
            break;
          end
        end
        pending_events.push_back(ev);
        n = 1;
      end
      KIND_FREE: begin
        if (slot_state[s] == ST_ARMED) begin
          foreach (armed_list[i]) begin
            if (armed_list[i] == s) begin
              armed_list.delete(i);
              break;
            end
          end
        end
        slot_state[s] = ST_UNUSED;
      end
      KIND_SETP: begin
        slot_pay[s] = pay;
        slot_dest[s] = dq;
        slot_written[s] = 1'b1;
      end
      KIND_ARM: begin
        if (slot_state[s] == ST_ALLOC) begin
          slot_deadline[s] = delay + now_ticks;
          slot_state[s] = ST_ARMED;
          // a new timer goes ahead of equal deadlines
          pos = 0;
          while (pos < armed_list.size() &&
                 slot_deadline[s] > slot_deadline[armed_list[pos]])
            pos++;
          armed_list.insert(pos, s);
        end
      end
      KIND_TICK: begin
        now_ticks++;
        want_switch = 1'b0;
        head = 0;
        while (head < armed_list.size() && n < MaxResults &&
               slot_deadline[armed_list[head]] <= now_ticks) begin
          slot_state[armed_list[head]] = ST_ALLOC;
          if (6'(armed_list[head]) == task_slot) begin
            want_switch = 1'b1;
          end else begin
            ev = '{RES_FIRED, 1'b0, 5'(armed_list[head]),
                   slot_pay[armed_list[head]], slot_dest[armed_list[head]], 1'b0};
            pending_events.push_back(ev);
            n++;
          end
          head++;
        end
        repeat (head) armed_list.pop_front();
        if (want_switch && n < MaxResults) begin
          ev = '{RES_SWITCH, 1'b0, task_slot[4:0], 32'd0, 4'd0, 1'b0};
          pending_events.push_back(ev);
          n++;
        end
      end
      default: ;
    endcase
    if (n > 0) pending_events[pending_events.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    timer_event_t ev;
    if (rst_n && out_strobe === 1'b1) begin
      events_seen++;
      if (out_result_kind == RES_FIRED) fires_seen++;
      if (out_result_kind == RES_SWITCH) switches_seen++;
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected event kind=%0d slot=%0d", $realtime,
                   out_result_kind, out_result_slot);
      end else begin
        ev = pending_events.pop_front();
        if (out_result_kind !== ev.rkind || out_granted !== ev.granted ||
            out_result_slot !== ev.slot || out_fired_payload !== ev.payload ||
            out_fired_queue !== ev.queue || out_last !== ev.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: mismatch exp kind=%0d gr=%0d slot=%0d pay=%h q=%0d last=%0d",
                     $realtime, ev.rkind, ev.granted, ev.slot, ev.payload,
                     ev.queue, ev.last);
            $display("%0t:          got kind=%0d gr=%0d slot=%0d pay=%h q=%0d last=%0d",
                     $realtime, out_result_kind, out_granted, out_result_slot,
                     out_fired_payload, out_fired_queue, out_last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  // Called and returns at a falling edge. Prediction happens at the edge that
  // accepts the beat, so the expected order matches the block's order.
  task automatic send_cmd(input logic [2:0] kind, input bit [4:0] s,
                          input bit [31:0] delay, input bit [31:0] pay,
                          input bit [3:0] dq);
    start = 1'b0;
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_kind = kind;
    in_slot = s;
    in_delay = delay;
    in_payload = pay;
    in_dest_queue = dq;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    model_command(kind, s, delay, pay, dq);
    beats_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // Drain, then let the back end finish any walk that produces no event.
  task automatic wait_quiet();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (IdleGuard) @(negedge clk);
  endtask

  task automatic write_task_slot(input bit [5:0] value);
    wait_quiet();
    cfg_task_timer_slot = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    task_slot = value;
  endtask

  // Random slot that is usually live, so arms and frees do real work.
  function automatic bit [4:0] pick_slot();
    int base;
    base = $urandom_range(NumSlots - 1);
    if ($urandom_range(99) < 80) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_state[(base + i) % NumSlots] != ST_UNUSED)
          return 5'((base + i) % NumSlots);
      end
    end
    return 5'(base);
  endfunction

  // ---------------------------------------------------------------- tests
  // Payload extremes, delay 0 and a wrapping delay, repeated arm, arm/free
  // of unused slots, free of an armed timer, reserved kinds, empty tick.
  task automatic test_corner_cases();
    send_cmd(KIND_ALLOC, 5'd0, 32'd0, 32'd0, 4'd0);
    send_cmd(KIND_ALLOC, 5'd0, 32'd0, 32'd0, 4'd0);
    send_cmd(KIND_ALLOC, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    send_cmd(KIND_SETP, 5'd0, 32'd0, 32'h8000_0000, 4'd0);
    send_cmd(KIND_SETP, 5'd1, 32'd0, 32'h7fff_ffff, 4'hf);
    send_cmd(KIND_SETP, 5'd2, 32'd0, 32'hffff_ffff, 4'd7);
    send_cmd(KIND_TICK, 5'd0, 32'd0, 32'd0, 4'd0);            // nothing armed
    send_cmd(KIND_ARM, 5'd0, 32'd0, 32'd0, 4'd0);             // due right away
    send_cmd(KIND_ARM, 5'd1, 32'hffff_ffff, 32'd0, 4'd0);     // wraps below now
    send_cmd(KIND_ARM, 5'd1, 32'd5, 32'd0, 4'd0);             // already armed
    send_cmd(KIND_ARM, 5'd2, 32'd1, 32'd0, 4'd0);
    send_cmd(KIND_ARM, 5'd31, 32'd1, 32'd0, 4'd0);            // unused slot
    send_cmd(KIND_FREE, 5'd2, 32'd0, 32'd0, 4'd0);            // armed slot
    send_cmd(KIND_FREE, 5'd30, 32'd0, 32'd0, 4'd0);           // unused slot
    send_cmd(KindReservedLo, 5'd0, 32'hffff_ffff, 32'hffff_ffff, 4'hf);
    send_cmd(KindReservedHi, 5'd1, 32'd0, 32'd0, 4'd0);
    send_cmd(KIND_TICK, 5'd0, 32'd0, 32'd0, 4'd0);
    send_cmd(KIND_TICK, 5'd0, 32'd0, 32'd0, 4'd0);
  endtask

  // Allocate one more than the pool size, so the surplus allocates fail, then release everything.
  task automatic test_pool_exhaustion();
    repeat (NumSlots + 1) send_cmd(KIND_ALLOC, 5'd0, 32'd0, 32'd0, 4'd0);
    for (int i = 0; i < NumSlots; i++)
      send_cmd(KIND_FREE, 5'(i), 32'd0, 32'd0, 4'd0);
  endtask

  // Equal deadlines fire newest first; the task timer fires last as a switch.
  task automatic test_task_switch();
    write_task_slot(6'd1);
    for (int i = 0; i < 3; i++) begin
      send_cmd(KIND_ALLOC, 5'd0, 32'd0, 32'd0, 4'd0);
      send_cmd(KIND_SETP, 5'(i), 32'd0, $urandom, 4'($urandom));
    end
    for (int i = 0; i < 3; i++)
      send_cmd(KIND_ARM, 5'(i), 32'd1, 32'd0, 4'd0);
    send_cmd(KIND_TICK, 5'd0, 32'd0, 32'd0, 4'd0);
  endtask

  task automatic test_random_phase(input int pct, input bit [5:0] tslot,
                                   input int count);
    int sel;
    logic [2:0] kind;
    bit [4:0] s;
    bit [31:0] delay;
    write_task_slot(tslot);
    idle_pct = pct;
    repeat (count) begin
      sel = $urandom_range(99);
      s = pick_slot();
      delay = ($urandom_range(99) < 85) ? 32'($urandom_range(4)) : $urandom;
      if (sel < 18) kind = KIND_ALLOC;
      else if (sel < 30) kind = KIND_SETP;
      else if (sel < 58) kind = KIND_ARM;
      else if (sel < 88) kind = KIND_TICK;
      else if (sel < 96) kind = KIND_FREE;
      else kind = 3'($urandom_range(KindReservedLo, KindReservedHi));
      // a timer may only fire once its payload has been set
      if (kind == KIND_ARM && !slot_written[s]) kind = KIND_SETP;
      send_cmd(kind, s, delay, $urandom, 4'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_ALLOC;
    in_slot = '0;
    in_delay = '0;
    in_payload = '0;
    in_dest_queue = '0;
    cfg_we = 1'b0;
    cfg_task_timer_slot = 6'd32;
    task_slot = 6'd32;
    now_ticks = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_state[i] = ST_UNUSED;
      slot_written[i] = 1'b0;
    end
    idle_pct = 22;
    beats_sent = 0;
    events_seen = 0;
    fires_seen = 0;
    switches_seen = 0;
    mismatch_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_pool_exhaustion();
    test_task_switch();
    test_random_phase(22, 6'd63, 30);
    test_random_phase(63, 6'd0, 30);
    test_random_phase(0, 6'($urandom_range(1, 6)), 30);

    wait_quiet();
    $display("Sent %0d command beats; checked %0d events (%0d fires, %0d switches).",
             beats_sent, events_seen, fires_seen, switches_seen);
    $display("Mismatches: %0d, events never seen: %0d", mismatch_count,
             pending_events.size());
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ sorted_timer_queue.f @@
rtl/stq_pkg.sv
rtl/stq_front.sv
rtl/stq_back.sv
rtl/sorted_timer_queue.sv
tb/sv/tb_sorted_timer_queue.sv
